// ===== rtl/lers_pkg.sv =====
// Package with the types and codes shared by the LOOK request scheduler modules.
package lers_pkg;

    localparam logic MODE_SUBMIT   = 1'b0;
    localparam logic MODE_COMPLETE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    typedef struct packed {
        logic [31:0] sector;
        logic [15:0] tag;
        logic [7:0]  count;
        logic        write;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/lers_ctrl.sv =====
// Controller state machine that sequences capture, execution and result hand-off.
module lers_ctrl import lers_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   fire;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        fire        = !r_out_valid || i_ready;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/lers_dp.sv =====
// Datapath with the sorted row of queue cells, sweep state and result register.
module lers_dp import lers_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_mode,
    input  logic [31:0] i_sector,
    input  logic [15:0] i_request_tag,
    input  logic [7:0]  i_block_count,
    input  logic        i_is_write,
    output logic        o_dispatch_valid,
    output logic [31:0] o_out_sector,
    output logic [15:0] o_out_tag,
    output logic [7:0]  o_out_count,
    output logic        o_out_write,
    output logic [1:0]  o_status
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          r_mode;
    t_entry        r_in;
    t_entry        r_ent [QUEUE_DEPTH];
    t_entry        n_ent [QUEUE_DEPTH];
    logic [CW-1:0] r_occ, n_occ;
    logic [IW-1:0] r_act, n_act;
    logic          r_down, n_down;

    logic          r_o_dv, n_o_dv;
    t_entry        r_o_ent, n_o_ent;
    logic [1:0]    r_o_status, n_o_status;

    logic [QUEUE_DEPTH-1:0] le;
    logic          full;
    logic          empty;
    logic          last;
    logic          first;
    logic          down_nx;
    logic          has_next;
    logic [IW-1:0] rd_idx;
    t_entry        rd_ent;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (CW'(i) < r_occ) && (r_ent[i].sector <= r_in.sector);
        end
        full     = (r_occ == CW'(QUEUE_DEPTH));
        empty    = (r_occ == '0);
        last     = ((CW'(r_act) + CW'(1)) == r_occ);
        first    = (r_act == '0);
        down_nx  = r_down;
        if (!r_down && last) begin
            down_nx = 1'b1;
        end else if (r_down && first) begin
            down_nx = 1'b0;
        end
        has_next = down_nx ? !first : !last;
        rd_idx   = down_nx ? (r_act - IW'(1)) : (r_act + IW'(1));
        rd_ent   = r_ent[rd_idx];

        n_ent      = r_ent;
        n_occ      = r_occ;
        n_act      = r_act;
        n_down     = r_down;
        n_o_dv     = 1'b0;
        n_o_ent    = '0;
        n_o_status = ST_OK;

        if (r_mode == MODE_SUBMIT) begin
            if (full) begin
                n_o_status = ST_FULL;
            end else begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (i > 0 && !le[(i > 0) ? i - 1 : 0]) begin
                        n_ent[i] = r_ent[(i > 0) ? i - 1 : 0];
                    end else if (!le[i]) begin
                        n_ent[i] = r_in;
                    end
                end
                n_occ = r_occ + CW'(1);
                if (empty) begin
                    n_act   = '0;
                    n_o_dv  = 1'b1;
                    n_o_ent = r_in;
                end else if (!le[r_act]) begin
                    n_act = r_act + IW'(1);
                end
            end
        end else begin
            if (empty) begin
                n_o_status = ST_IDLE;
            end else begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    if (IW'(i) >= r_act) begin
                        n_ent[i] = r_ent[i + 1];
                    end
                end
                n_occ  = r_occ - CW'(1);
                n_down = down_nx;
                if (has_next) begin
                    n_act   = down_nx ? (r_act - IW'(1)) : r_act;
                    n_o_dv  = 1'b1;
                    n_o_ent = rd_ent;
                end else begin
                    n_act = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode       <= i_mode;
            r_in.sector  <= i_sector;
            r_in.tag     <= i_request_tag;
            r_in.count   <= i_block_count;
            r_in.write   <= i_is_write;
        end
        if (i_cmd.exec) begin
            r_ent      <= n_ent;
            r_o_dv     <= n_o_dv;
            r_o_ent    <= n_o_ent;
            r_o_status <= n_o_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_act  <= '0;
            r_down <= 1'b0;
        end else if (i_cmd.exec) begin
            r_occ  <= n_occ;
            r_act  <= n_act;
            r_down <= n_down;
        end
    end

    assign o_dispatch_valid = r_o_dv;
    assign o_out_sector     = r_o_ent.sector;
    assign o_out_tag        = r_o_ent.tag;
    assign o_out_count      = r_o_ent.count;
    assign o_out_write      = r_o_ent.write;
    assign o_status         = r_o_status;

endmodule

// ===== rtl/look_elevator_request_scheduler.sv =====
// Top level of the LOOK elevator block-request scheduler.
// Each transaction is a submission or a completion and yields exactly one result. A
// transaction is first captured; then, in its execute step, the row of queue
// cells compares every entry against the new sector in parallel and shifts in place,
// or closes the gap left by the completed request and selects its neighbour. A new
// transaction is taken while the previous result still waits in the output register;
// it only stalls in its execute step if that result has not yet been taken.
module look_elevator_request_scheduler import lers_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [31:0] i_sector,
    input  logic [15:0] i_request_tag,
    input  logic [7:0]  i_block_count,
    input  logic        i_is_write,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_dispatch_valid,
    output logic [31:0] o_out_sector,
    output logic [15:0] o_out_tag,
    output logic [7:0]  o_out_count,
    output logic        o_out_write,
    output logic [1:0]  o_status
);

    t_cmd cmd;

    lers_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    lers_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_mode           (i_mode),
        .i_sector         (i_sector),
        .i_request_tag    (i_request_tag),
        .i_block_count    (i_block_count),
        .i_is_write       (i_is_write),
        .o_dispatch_valid (o_dispatch_valid),
        .o_out_sector     (o_out_sector),
        .o_out_tag        (o_out_tag),
        .o_out_count      (o_out_count),
        .o_out_write      (o_out_write),
        .o_status         (o_status)
    );

endmodule

// ===== rtl/lers_checker.sv =====
// Port-level checker for the LOOK request scheduler, bound to the top level.
module lers_checker import lers_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_mode,
    input logic [31:0] i_sector,
    input logic [15:0] i_request_tag,
    input logic [7:0]  i_block_count,
    input logic        i_is_write,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_dispatch_valid,
    input logic [31:0] o_out_sector,
    input logic [15:0] o_out_tag,
    input logic [7:0]  o_out_count,
    input logic        o_out_write,
    input logic [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dispatch_valid)
            && $stable(o_out_sector) && $stable(o_out_tag) && $stable(o_status))
        else $error("Result changed while stalled.");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dispatch_valid |-> o_out_sector == 32'd0 && o_out_tag == 16'd0
            && o_out_count == 8'd0 && !o_out_write)
        else $error("Result fields not zero without a dispatch.");

    a_err_no_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> !o_dispatch_valid)
        else $error("Dispatch reported together with an error status.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_FULL || o_status == ST_IDLE)
        else $error("Undefined status code.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Second transaction accepted while one is in progress.");

endmodule

bind look_elevator_request_scheduler lers_checker u_lers_checker (.*);
